[sv/scc_pkg.sv]
// Shared types and constants for the stick calibrate-and-curve block.
package scc_pkg;

    localparam int unsigned NUM_AXES   = 4;
    localparam int unsigned AXIS_IDX_W = $clog2(NUM_AXES);
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned AXIS_W     = 17;
    localparam int unsigned OFF_W      = 14;
    localparam int unsigned SCALED_W   = 11;
    localparam int unsigned DIFF_W     = 15;
    localparam int unsigned MAG_W      = 13;
    localparam int unsigned QUOT_W     = 16;
    localparam int unsigned FRAMES_W   = 3;

    // Shared multiplier geometry
    localparam int unsigned MUL_A_W    = 26;
    localparam int unsigned MUL_B_W    = 17;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

    // Scaling: trunc(adc * 1998 / 4096) - 999
    localparam logic [10:0] SCALE_GAIN  = 11'd1998;
    localparam int unsigned SCALE_SHIFT = 12;
    localparam logic [11:0] SCALE_BIAS  = 12'd999;

    // Curve: trunc(d * d / 1000) via reciprocal floor(2^26 / 1000) plus one correction
    localparam logic [9:0]  CURVE_DIV   = 10'd1000;
    localparam int unsigned CURVE_SHIFT = 26;
    localparam logic [16:0] CURVE_RECIP = 17'd67108;

    // Calibration average uses a reciprocal with this many fraction bits
    localparam int unsigned CAL_SHIFT   = 16;

    // Axes whose curved value is negated
    localparam logic [NUM_AXES-1:0] AXIS_FLIP = 4'b0101;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFS,
        ST_CAL_ABS,
        ST_CAL_Q,
        ST_CAL_FIX,
        ST_SQ,
        ST_DIV_X,
        ST_DIV_Q,
        ST_DIV_FIX,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_SCALE,
        MS_CAL_RECIP,
        MS_CAL_BACK,
        MS_SQUARE,
        MS_DIV_RECIP,
        MS_DIV_BACK
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        t_mul_sel mul_sel;
        logic     do_offs;
        logic     do_cal_abs;
        logic     do_cal_q;
        logic     do_cal_fix;
        logic     do_sq;
        logic     do_div_x;
        logic     do_div_q;
        logic     do_div_fix;
        logic     do_done;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic cal_last;
        logic axis_last;
    } t_stat;

endpackage

[sv/scc_mul.sv]
// Shared unsigned multiplier with registered product.
module scc_mul (
    input  logic                               i_clk,
    input  logic [scc_pkg::MUL_A_W-1:0]        i_a,
    input  logic [scc_pkg::MUL_B_W-1:0]        i_b,
    output logic [scc_pkg::PROD_W-1:0]         o_prod
);

    logic [scc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= scc_pkg::PROD_W'(i_a) * scc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[sv/scc_seq.sv]
// Sequencer that steps each axis through the shared multiplier.
module scc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scc_pkg::t_stat  i_stat,
    output scc_pkg::t_ctrl  o_ctrl
);

    scc_pkg::t_state r_state;
    scc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scc_pkg::ST_IDLE: begin
                if (i_stat.in_valid) n_state = scc_pkg::ST_SCALE;
            end
            scc_pkg::ST_SCALE:   n_state = scc_pkg::ST_OFFS;
            scc_pkg::ST_OFFS: begin
                // last calibration frame: average the offset before use
                n_state = i_stat.cal_last ? scc_pkg::ST_CAL_ABS : scc_pkg::ST_SQ;
            end
            scc_pkg::ST_CAL_ABS: n_state = scc_pkg::ST_CAL_Q;
            scc_pkg::ST_CAL_Q:   n_state = scc_pkg::ST_CAL_FIX;
            scc_pkg::ST_CAL_FIX: n_state = scc_pkg::ST_SQ;
            scc_pkg::ST_SQ:      n_state = scc_pkg::ST_DIV_X;
            scc_pkg::ST_DIV_X:   n_state = scc_pkg::ST_DIV_Q;
            scc_pkg::ST_DIV_Q:   n_state = scc_pkg::ST_DIV_FIX;
            scc_pkg::ST_DIV_FIX: begin
                n_state = i_stat.axis_last ? scc_pkg::ST_DONE : scc_pkg::ST_SCALE;
            end
            scc_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = scc_pkg::ST_IDLE;
            end
            default:             n_state = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.mul_sel = scc_pkg::MS_NONE;
        unique case (r_state)
            scc_pkg::ST_IDLE:    o_ctrl.in_ready = 1'b1;
            scc_pkg::ST_SCALE:   o_ctrl.mul_sel = scc_pkg::MS_SCALE;
            scc_pkg::ST_OFFS:    o_ctrl.do_offs = 1'b1;
            scc_pkg::ST_CAL_ABS: begin
                o_ctrl.do_cal_abs = 1'b1;
                o_ctrl.mul_sel    = scc_pkg::MS_CAL_RECIP;
            end
            scc_pkg::ST_CAL_Q: begin
                o_ctrl.do_cal_q = 1'b1;
                o_ctrl.mul_sel  = scc_pkg::MS_CAL_BACK;
            end
            scc_pkg::ST_CAL_FIX: o_ctrl.do_cal_fix = 1'b1;
            scc_pkg::ST_SQ: begin
                o_ctrl.do_sq   = 1'b1;
                o_ctrl.mul_sel = scc_pkg::MS_SQUARE;
            end
            scc_pkg::ST_DIV_X: begin
                o_ctrl.do_div_x = 1'b1;
                o_ctrl.mul_sel  = scc_pkg::MS_DIV_RECIP;
            end
            scc_pkg::ST_DIV_Q: begin
                o_ctrl.do_div_q = 1'b1;
                o_ctrl.mul_sel  = scc_pkg::MS_DIV_BACK;
            end
            scc_pkg::ST_DIV_FIX: o_ctrl.do_div_fix = 1'b1;
            scc_pkg::ST_DONE:    o_ctrl.do_done = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

[sv/stick_calibrate_and_curve.sv]
// Top level: joystick frame calibration and square-curve shaping.
//
// Input channel: i_valid / o_ready carry one frame (four 12-bit samples and
// two button levels). Output channel: o_valid / i_ready carry one result per
// frame (four signed 17-bit axes and the two switch levels).
// Each axis makes four or six passes through one shared multiplier
// (scale, square, reciprocal divide by 1000 with a back-multiply for the
// correction, and on the last calibration frame a reciprocal average).
// A frame steps each axis through the scale, offset, square and divide states,
// plus the calibration states on the last calibration frame. The done state then
// loads the output register, so o_valid rises at the edge that ends it, and
// o_ready rises at that same edge.
// A finished result waits in the output register while the next frame is
// taken in; if the receiver still stalls when the next frame finishes, the
// sequencer holds and o_ready stays low.
// Reset clears the offsets, reloads the calibration frame count and empties
// the output register. The first CAL_FRAMES frames after reset calibrate.
module stick_calibrate_and_curve #(
    parameter int unsigned CAL_FRAMES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [scc_pkg::ADC_W-1:0]           i_stick_0,
    input  logic [scc_pkg::ADC_W-1:0]           i_stick_1,
    input  logic [scc_pkg::ADC_W-1:0]           i_stick_2,
    input  logic [scc_pkg::ADC_W-1:0]           i_stick_3,
    input  logic                                i_button_a,
    input  logic                                i_button_b,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [scc_pkg::AXIS_W-1:0]   o_axis_0,
    output logic signed [scc_pkg::AXIS_W-1:0]   o_axis_1,
    output logic signed [scc_pkg::AXIS_W-1:0]   o_axis_2,
    output logic signed [scc_pkg::AXIS_W-1:0]   o_axis_3,
    output logic                                o_switch_a,
    output logic                                o_switch_b
);

    localparam int unsigned NA = scc_pkg::NUM_AXES;
    localparam int unsigned IW = scc_pkg::AXIS_IDX_W;
    localparam logic [scc_pkg::MUL_B_W-1:0] CAL_RECIP =
        scc_pkg::MUL_B_W'((1 << scc_pkg::CAL_SHIFT) / CAL_FRAMES);
    localparam logic [scc_pkg::MUL_B_W-1:0] CAL_DIV = scc_pkg::MUL_B_W'(CAL_FRAMES);

    scc_pkg::t_ctrl w_ctrl;
    scc_pkg::t_stat w_stat;

    // control registers
    logic [IW-1:0]                       r_axis,   n_axis;
    logic [scc_pkg::FRAMES_W-1:0]        r_frames, n_frames;
    logic signed [scc_pkg::OFF_W-1:0]    r_off [NA];
    logic signed [scc_pkg::OFF_W-1:0]    n_off [NA];
    logic                                r_o_valid, n_o_valid;

    // payload registers
    logic [scc_pkg::ADC_W-1:0]           r_adc [NA];
    logic [scc_pkg::ADC_W-1:0]           n_adc [NA];
    logic                                r_btn_a, n_btn_a, r_btn_b, n_btn_b;
    logic signed [scc_pkg::SCALED_W-1:0] r_s, n_s;
    logic [scc_pkg::MAG_W-1:0]           r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic [scc_pkg::MUL_A_W-1:0]         r_x, n_x;
    logic [scc_pkg::QUOT_W-1:0]          r_q, n_q;
    logic signed [scc_pkg::AXIS_W-1:0]   r_res [NA];
    logic signed [scc_pkg::AXIS_W-1:0]   n_res [NA];
    logic signed [scc_pkg::AXIS_W-1:0]   r_o_axis [NA];
    logic signed [scc_pkg::AXIS_W-1:0]   n_o_axis [NA];
    logic                                r_o_sw_a, n_o_sw_a, r_o_sw_b, n_o_sw_b;

    // datapath wires
    logic [scc_pkg::MUL_A_W-1:0]         w_mul_a;
    logic [scc_pkg::MUL_B_W-1:0]         w_mul_b;
    logic [scc_pkg::PROD_W-1:0]          w_prod;
    logic                                w_accept;
    logic                                w_axis_last;
    logic signed [scc_pkg::OFF_W-1:0]    w_off_cur;
    logic [scc_pkg::MAG_W-1:0]           w_off_mag;
    logic signed [scc_pkg::SCALED_W-1:0] w_s;
    logic [scc_pkg::MAG_W-1:0]           w_cal_q0;
    logic [scc_pkg::OFF_W-1:0]           w_cal_rem;
    logic [scc_pkg::MAG_W-1:0]           w_cal_q;
    logic signed [scc_pkg::OFF_W-1:0]    w_off_avg;
    logic signed [scc_pkg::DIFF_W-1:0]   w_d;
    logic [scc_pkg::MAG_W-1:0]           w_d_mag;
    logic [scc_pkg::QUOT_W-1:0]          w_div_q0;
    logic [scc_pkg::MUL_A_W-1:0]         w_div_rem;
    logic signed [scc_pkg::AXIS_W-1:0]   w_div_q;
    logic signed [scc_pkg::AXIS_W-1:0]   w_curved;

    scc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    scc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept    = w_ctrl.in_ready && i_valid;
    assign w_axis_last = (r_axis == IW'(NA - 1));

    assign w_stat.in_valid  = i_valid;
    assign w_stat.out_free  = !r_o_valid || i_ready;
    assign w_stat.cal_last  = (r_frames == scc_pkg::FRAMES_W'(1));
    assign w_stat.axis_last = w_axis_last;

    // per-axis arithmetic around the shared multiplier
    assign w_off_cur = r_off[r_axis];
    assign w_off_mag = scc_pkg::MAG_W'(w_off_cur[scc_pkg::OFF_W-1] ? -w_off_cur : w_off_cur);
    assign w_s = scc_pkg::SCALED_W'(
        $signed({1'b0, w_prod[scc_pkg::SCALE_SHIFT +: scc_pkg::SCALED_W]})
        - $signed(scc_pkg::SCALE_BIAS));

    assign w_cal_q0  = w_prod[scc_pkg::CAL_SHIFT +: scc_pkg::MAG_W];
    assign w_cal_rem = {1'b0, r_mag} - w_prod[scc_pkg::OFF_W-1:0];
    assign w_cal_q   = r_q[scc_pkg::MAG_W-1:0]
                     + scc_pkg::MAG_W'(w_cal_rem >= scc_pkg::OFF_W'(CAL_DIV));
    assign w_off_avg = w_off_cur[scc_pkg::OFF_W-1]
                     ? -$signed({1'b0, w_cal_q}) : $signed({1'b0, w_cal_q});

    assign w_d     = scc_pkg::DIFF_W'(r_s) - scc_pkg::DIFF_W'(w_off_cur);
    assign w_d_mag = scc_pkg::MAG_W'(w_d[scc_pkg::DIFF_W-1] ? -w_d : w_d);

    assign w_div_q0  = w_prod[scc_pkg::CURVE_SHIFT +: scc_pkg::QUOT_W];
    assign w_div_rem = r_x - w_prod[scc_pkg::MUL_A_W-1:0];
    assign w_div_q   = $signed({1'b0, r_q})
                     + $signed(scc_pkg::AXIS_W'(w_div_rem >= scc_pkg::MUL_A_W'(scc_pkg::CURVE_DIV)));
    assign w_curved  = (r_neg ^ scc_pkg::AXIS_FLIP[r_axis]) ? -w_div_q : w_div_q;

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (w_ctrl.mul_sel)
            scc_pkg::MS_NONE: begin
            end
            scc_pkg::MS_SCALE: begin
                w_mul_a = scc_pkg::MUL_A_W'(r_adc[r_axis]);
                w_mul_b = scc_pkg::MUL_B_W'(scc_pkg::SCALE_GAIN);
            end
            scc_pkg::MS_CAL_RECIP: begin
                w_mul_a = scc_pkg::MUL_A_W'(w_off_mag);
                w_mul_b = CAL_RECIP;
            end
            scc_pkg::MS_CAL_BACK: begin
                w_mul_a = scc_pkg::MUL_A_W'(w_cal_q0);
                w_mul_b = CAL_DIV;
            end
            scc_pkg::MS_SQUARE: begin
                w_mul_a = scc_pkg::MUL_A_W'(w_d_mag);
                w_mul_b = scc_pkg::MUL_B_W'(w_d_mag);
            end
            scc_pkg::MS_DIV_RECIP: begin
                w_mul_a = w_prod[scc_pkg::MUL_A_W-1:0];
                w_mul_b = scc_pkg::CURVE_RECIP;
            end
            scc_pkg::MS_DIV_BACK: begin
                w_mul_a = scc_pkg::MUL_A_W'(w_div_q0);
                w_mul_b = scc_pkg::MUL_B_W'(scc_pkg::CURVE_DIV);
            end
            default: begin
            end
        endcase
    end

    // next-state datapath
    always_comb begin
        n_axis    = r_axis;
        n_frames  = r_frames;
        n_off     = r_off;
        n_o_valid = r_o_valid;
        n_adc     = r_adc;
        n_btn_a   = r_btn_a;
        n_btn_b   = r_btn_b;
        n_s       = r_s;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_x       = r_x;
        n_q       = r_q;
        n_res     = r_res;
        n_o_axis  = r_o_axis;
        n_o_sw_a  = r_o_sw_a;
        n_o_sw_b  = r_o_sw_b;

        if (r_o_valid && i_ready) n_o_valid = 1'b0;

        if (w_accept) begin
            n_adc[0] = i_stick_0;
            n_adc[1] = i_stick_1;
            n_adc[2] = i_stick_2;
            n_adc[3] = i_stick_3;
            n_btn_a  = i_button_a;
            n_btn_b  = i_button_b;
            n_axis   = '0;
        end
        if (w_ctrl.do_offs) begin
            n_s = w_s;
            // accumulate while calibrating; the running sum is used as is
            if (r_frames != '0) begin
                n_off[r_axis] = w_off_cur + scc_pkg::OFF_W'(w_s);
            end
        end
        if (w_ctrl.do_cal_abs) n_mag = w_off_mag;
        if (w_ctrl.do_cal_q)   n_q   = scc_pkg::QUOT_W'(w_cal_q0);
        if (w_ctrl.do_cal_fix) n_off[r_axis] = w_off_avg;
        if (w_ctrl.do_sq) begin
            n_neg = w_d[scc_pkg::DIFF_W-1];
            n_mag = w_d_mag;
        end
        if (w_ctrl.do_div_x) n_x = w_prod[scc_pkg::MUL_A_W-1:0];
        if (w_ctrl.do_div_q) n_q = w_div_q0;
        if (w_ctrl.do_div_fix) begin
            n_res[r_axis] = w_curved;
            n_axis = w_axis_last ? '0 : r_axis + IW'(1);
            if (w_axis_last && r_frames != '0) n_frames = r_frames - scc_pkg::FRAMES_W'(1);
        end
        if (w_ctrl.do_done && w_stat.out_free) begin
            n_o_axis  = r_res;
            n_o_sw_a  = r_btn_a;
            n_o_sw_b  = r_btn_b;
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis    <= '0;
            r_frames  <= scc_pkg::FRAMES_W'(CAL_FRAMES);
            r_o_valid <= 1'b0;
            for (int i = 0; i < NA; i++) begin
                r_off[i] <= '0;
            end
        end else begin
            r_axis    <= n_axis;
            r_frames  <= n_frames;
            r_o_valid <= n_o_valid;
            r_off     <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adc    <= n_adc;
        r_btn_a  <= n_btn_a;
        r_btn_b  <= n_btn_b;
        r_s      <= n_s;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_x      <= n_x;
        r_q      <= n_q;
        r_res    <= n_res;
        r_o_axis <= n_o_axis;
        r_o_sw_a <= n_o_sw_a;
        r_o_sw_b <= n_o_sw_b;
    end

    assign o_ready    = w_ctrl.in_ready;
    assign o_valid    = r_o_valid;
    assign o_axis_0   = r_o_axis[0];
    assign o_axis_1   = r_o_axis[1];
    assign o_axis_2   = r_o_axis[2];
    assign o_axis_3   = r_o_axis[3];
    assign o_switch_a = r_o_sw_a;
    assign o_switch_b = r_o_sw_b;

`ifndef ASSERT_OFF
    // reciprocal estimates are never more than one below the true quotient
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.do_div_fix |-> (w_div_rem < 2 * scc_pkg::MUL_A_W'(scc_pkg::CURVE_DIV)))
        else $error("curve remainder out of range");

    a_cal_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.do_cal_fix |-> (w_cal_rem < 2 * scc_pkg::OFF_W'(CAL_DIV)))
        else $error("calibration remainder out of range");

    // frame count stays within its reset value, and the axis index is zero while idle
    a_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames <= scc_pkg::FRAMES_W'(CAL_FRAMES)) && (!w_ctrl.in_ready || (r_axis == '0)))
        else $error("frame count or axis index corrupt");

    // results appear only from the done step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(w_ctrl.do_done))
        else $error("output loaded outside done step");

    for (genvar g = 0; g < NA; g++) begin : g_off_hold
        a_off_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_frames == '0) |=> (r_frames == '0) && $stable(r_off[g]))
            else $error("offset changed after calibration");
    end
`endif

endmodule

[bench/tb_stick_calibrate_and_curve.sv]
// Testbench for stick_calibrate_and_curve: directed and random frames checked against a predictor.
module tb_stick_calibrate_and_curve;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NAX = scc_pkg::NUM_AXES;
    localparam int unsigned AW  = scc_pkg::ADC_W;
    localparam int unsigned XW  = scc_pkg::AXIS_W;

    localparam int SCALE_MUL     = 1998;
    localparam int SCALE_DEN     = 4096;
    localparam int SCALE_OFFSET  = 999;
    localparam int SQUARE_DIV    = 1000;
    localparam int CAL_COUNT     = 5;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 100;
    localparam int RANDOM_FRAMES = 1100;
    localparam int STEADY_FRAMES = 180;

    typedef struct packed {
        logic [NAX-1:0][XW-1:0] axis;
        logic                   sw_a;
        logic                   sw_b;
    } t_stick_report;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic          o_ready;
    logic [AW-1:0] i_stick_0  = '0;
    logic [AW-1:0] i_stick_1  = '0;
    logic [AW-1:0] i_stick_2  = '0;
    logic [AW-1:0] i_stick_3  = '0;
    logic          i_button_a = 1'b0;
    logic          i_button_b = 1'b0;
    logic          o_valid;
    logic          i_ready    = 1'b0;
    logic signed [XW-1:0] o_axis_0;
    logic signed [XW-1:0] o_axis_1;
    logic signed [XW-1:0] o_axis_2;
    logic signed [XW-1:0] o_axis_3;
    logic          o_switch_a;
    logic          o_switch_b;

    // Predictor state: per-channel center offset and calibration frames still to come
    int stick_center [NAX];
    int cal_frames_left;

    t_stick_report curved_frames_due [$];

    int  error_count   = 0;
    int  frames_sent   = 0;
    int  results_seen  = 0;
    bit  tx_idling     = 1'b0;
    bit  rx_idling     = 1'b0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  rx_hold_left  = 0;
    int  rx_gap_left   = 0;

    stick_calibrate_and_curve dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_stick_0  (i_stick_0),
        .i_stick_1  (i_stick_1),
        .i_stick_2  (i_stick_2),
        .i_stick_3  (i_stick_3),
        .i_button_a (i_button_a),
        .i_button_b (i_button_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_axis_0   (o_axis_0),
        .o_axis_1   (o_axis_1),
        .o_axis_2   (o_axis_2),
        .o_axis_3   (o_axis_3),
        .o_switch_a (o_switch_a),
        .o_switch_b (o_switch_b)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Scale, accumulate the center during calibration, then square-curve each channel.
    function automatic t_stick_report curve_frame(input logic [NAX-1:0][AW-1:0] sticks,
                                                  input logic btn_a, input logic btn_b);
        t_stick_report r;
        int scaled [NAX];
        int diff;
        int mag;
        for (int i = 0; i < NAX; i++) begin
            scaled[i] = (int'(sticks[i]) * SCALE_MUL) / SCALE_DEN - SCALE_OFFSET;
        end
        if (cal_frames_left > 0) begin
            for (int i = 0; i < NAX; i++) begin
                stick_center[i] += scaled[i];
            end
            cal_frames_left--;
            if (cal_frames_left == 0) begin
                for (int i = 0; i < NAX; i++) begin
                    stick_center[i] = stick_center[i] / CAL_COUNT;
                end
            end
        end
        for (int i = 0; i < NAX; i++) begin
            diff = scaled[i] - stick_center[i];
            mag  = (diff * diff) / SQUARE_DIV;
            if (diff < 0) begin
                mag = -mag;
            end
            if (scc_pkg::AXIS_FLIP[i]) begin
                mag = -mag;
            end
            r.axis[i] = mag[XW-1:0];
        end
        r.sw_a = btn_a;
        r.sw_b = btn_b;
        return r;
    endfunction

    function automatic logic [AW-1:0] pick_sample();
        unique case ($urandom_range(0, 5))
            0, 1:    return AW'($urandom_range(0, 4095));
            2:       return AW'($urandom_range(1984, 2111));
            3:       return AW'($urandom_range(0, 15));
            4:       return AW'($urandom_range(4080, 4095));
            default: return AW'($urandom);
        endcase
    endfunction

    // Offer one frame and hold it until the block takes it.
    task automatic send_frame(input logic [AW-1:0] s0, input logic [AW-1:0] s1,
                              input logic [AW-1:0] s2, input logic [AW-1:0] s3,
                              input logic btn_a, input logic btn_b);
        logic [NAX-1:0][AW-1:0] sticks;
        sticks = {s3, s2, s1, s0};
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_stick_0  <= s0;
        i_stick_1  <= s1;
        i_stick_2  <= s2;
        i_stick_3  <= s3;
        i_button_a <= btn_a;
        i_button_b <= btn_b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        curved_frames_due.push_back(curve_frame(sticks, btn_a, btn_b));
        frames_sent++;
    endtask

    task automatic send_random_frame();
        send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Five calibration frames. The first cancels to zero on every axis, the next three
    // subtract the running sum, the fifth divides it. Channels 0 and 1 push the sums
    // to both extremes; channel 3 ends on a negative sum that truncates toward zero.
    task automatic test_calibration();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_frame(12'd4095, 12'd0, 12'd4095, 12'd0,    1'b1, 1'b1);
        send_frame(12'd4095, 12'd0, 12'd0,    12'd4095, 1'b0, 1'b0);
        send_frame(12'd4095, 12'd0, 12'd4095, 12'd0,    1'b1, 1'b0);
        send_frame(12'd4095, 12'd0, 12'd0,    12'd1000, 1'b0, 1'b1);
        send_frame(12'd4095, 12'd0, 12'd2100, 12'd3000, 1'b1, 1'b1);
    endtask

    // Offsets are now fixed; sweep the sample extremes and bit patterns.
    task automatic test_extremes();
        send_frame(12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b0);
        send_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1);
        send_frame(12'd2048, 12'd2048, 12'd2048, 12'd2048, 1'b0, 1'b1);
        send_frame(12'hAAA,  12'hAAA,  12'hAAA,  12'hAAA,  1'b1, 1'b0);
        send_frame(12'h555,  12'h555,  12'h555,  12'h555,  1'b0, 1'b0);
        send_frame(12'd0,    12'd4095, 12'd0,    12'd4095, 1'b1, 1'b1);
        send_frame(12'd4095, 12'd0,    12'd4095, 12'd0,    1'b0, 1'b1);
        send_frame(12'd2100, 12'd3000, 12'd1000, 12'd2047, 1'b1, 1'b0);
        send_frame(12'd1,    12'd4094, 12'd2047, 12'd2049, 1'b0, 1'b0);
        send_frame(12'hFFE,  12'h001,  12'h800,  12'h7FF,  1'b1, 1'b1);
    endtask

    // Receiver holds off while frames keep coming, so the block fills and stalls its input.
    task automatic test_output_stall();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_requests++;
        repeat (6) send_random_frame();
    endtask

    task automatic test_random_frames(input int count);
        int left_in_stretch;
        left_in_stretch = 0;
        for (int k = 0; k < count; k++) begin
            if (left_in_stretch == 0) begin
                left_in_stretch = $urandom_range(30, 80);
                tx_idling = ($urandom_range(0, 3) != 0);
                rx_idling = ($urandom_range(0, 3) != 0);
            end
            left_in_stretch--;
            send_random_frame();
        end
    endtask

    task automatic test_steady_stream(input int count);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (count) send_random_frame();
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (curved_frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (curved_frames_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", curved_frames_due.size()));
        end
    endtask

    // Receiver side: long hold-offs on request, otherwise short random stalls when rx_idling is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_ready      <= 1'b0;
            hold_served  <= hold_served + 1;
            rx_hold_left <= HOLD_CYCLES - 1;
        end else if (rx_gap_left > 0) begin
            i_ready     <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end else if (rx_idling && $urandom_range(0, 4) == 0) begin
            i_ready     <= 1'b0;
            rx_gap_left <= $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_stick_report got;
        t_stick_report want;
        if (i_rst_n && o_valid && i_ready) begin
            got.axis = {o_axis_3, o_axis_2, o_axis_1, o_axis_0};
            got.sw_a = o_switch_a;
            got.sw_b = o_switch_b;
            if (curved_frames_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = curved_frames_due.pop_front();
                for (int i = 0; i < NAX; i++) begin
                    if (got.axis[i] !== want.axis[i]) begin
                        report_mismatch($sformatf("result %0d axis_%0d: got %0d, want %0d",
                                                  results_seen, i, $signed(got.axis[i]),
                                                  $signed(want.axis[i])));
                    end
                end
                if (got.sw_a !== want.sw_a) begin
                    report_mismatch($sformatf("result %0d switch_a: got %b, want %b",
                                              results_seen, got.sw_a, want.sw_a));
                end
                if (got.sw_b !== want.sw_b) begin
                    report_mismatch($sformatf("result %0d switch_b: got %b, want %b",
                                              results_seen, got.sw_b, want.sw_b));
                end
            end
            results_seen++;
        end
    end

    initial begin
        for (int i = 0; i < NAX; i++) begin
            stick_center[i] = 0;
        end
        cal_frames_left = CAL_COUNT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_calibration();
        test_extremes();
        test_output_stall();
        test_random_frames(RANDOM_FRAMES);
        test_steady_stream(STEADY_FRAMES);
        drain_results();
        $display("covered: %0d frames sent, %0d results checked, %0d errors",
                 frames_sent, results_seen, error_count);
        $display("covered: calibration, sample extremes, long output hold-off, random stalls");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
